// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the overlay compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CKSO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define CKSO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ckso_pkg.sv -----
// Shared types and constants of the color-keyed overlay compositor.
`timescale 1ns / 1ps
package ckso_pkg;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 8;
  localparam int SHIFT_W = 7;

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [SHIFT_W-1:0] shift_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Overlay color key: transparent texel.
  localparam pixel_t KEY_TRANSPARENT = 8'hFF;

  // Memory-port control from the decode stage.
  typedef struct packed {
    logic ov_we;   // write overlay store
    logic bg_we;   // write background store
    logic rd_en;   // render lookup in both stores
  } ctl_t;

endpackage

// ----- hw/rtl/ckso_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module ckso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ckso_addr.sv -----
// Command decode: store selection, texel keying and address generation.
`timescale 1ns / 1ps
module ckso_addr #(
  parameter int TILE_SIDE = 128
) (
  input  logic                         start,
  input  logic                         busy,
  input  logic                         cmd,
  input  ckso_pkg::row_t               row,
  input  ckso_pkg::col_t               col,
  input  ckso_pkg::pixel_t             texel,
  input  ckso_pkg::shift_t             shift,
  output ckso_pkg::ctl_t               ctl,
  output logic [2*$clog2(TILE_SIDE)-1:0] waddr,
  output ckso_pkg::pixel_t             ov_wdata,
  output logic [2*$clog2(TILE_SIDE)-1:0] ov_raddr,
  output logic [2*$clog2(TILE_SIDE)-1:0] bg_raddr
);
  import ckso_pkg::*;

  localparam int SW = $clog2(TILE_SIDE);
  localparam logic [9:0] SIDE_V  = 10'(TILE_SIDE);
  localparam logic [9:0] SIDE2_V = 10'(2 * TILE_SIDE);

  logic       accept;
  logic [9:0] row_e;
  logic [9:0] col_e;
  logic [8:0] srow_sum;
  logic [8:0] scol_sum;
  logic       in_src;
  logic       right_half;

  assign accept = start & ~busy;
  assign row_e  = {3'b000, row};
  assign col_e  = {2'b00, col};

  // Load: rows and columns outside the double-wide source are dropped.
  assign in_src     = (row_e < SIDE_V) && (col_e < SIDE2_V);
  assign right_half = col_e[SW];

  assign ctl.ov_we = accept && (cmd == CMD_LOAD) && in_src && !right_half;
  assign ctl.bg_we = accept && (cmd == CMD_LOAD) && in_src && right_half;
  assign ctl.rd_en = accept && (cmd == CMD_RENDER);

  // Tile side is a power of two: wrap is the low bits.
  assign waddr    = {row_e[SW-1:0], col_e[SW-1:0]};
  assign ov_wdata = (texel == '0) ? KEY_TRANSPARENT : texel;

  assign srow_sum = {2'b00, row} + {2'b00, shift};
  assign scol_sum = {1'b0, col} + {2'b00, shift};
  assign ov_raddr = {srow_sum[SW-1:0], scol_sum[SW-1:0]};
  assign bg_raddr = {row_e[SW-1:0], col_e[SW-1:0]};

endmodule

// ----- hw/rtl/ckso_compose.sv -----
// Color-key select between overlay and background read data, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ckso_compose (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  ckso_pkg::pixel_t ov_rdata,
  input  ckso_pkg::pixel_t bg_rdata,
  output logic             out_valid,
  output ckso_pkg::pixel_t out_pixel
);
  import ckso_pkg::*;

  logic   rd_pend_r;
  logic   rd_pend_nxt;
  logic   valid_r;
  logic   valid_nxt;
  pixel_t pixel_r;
  pixel_t pixel_nxt;

  assign rd_pend_nxt = rd_en;
  assign valid_nxt   = rd_pend_r;
  assign pixel_nxt   = (ov_rdata == KEY_TRANSPARENT) ? bg_rdata : ov_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      rd_pend_r <= rd_pend_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

  // A keyed result can only come from a keyed background texel.
  `CKSO_ASSERT(a_key_from_bg, clk, rst_n, (valid_r && pixel_r == KEY_TRANSPARENT) |-> $past(bg_rdata == KEY_TRANSPARENT), "keyed pixel without keyed background")

endmodule

// ----- hw/rtl/color_keyed_scrolling_overlay_unit.sv -----
// Top level of the color-keyed scrolling overlay compositor.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ----------------------------
//  input     in_cmd, in_row, in_col, in_texel, in_shift    taken when start && !busy
//  result    out_pixel                                     out_valid strobe, one cycle
//
// One transaction per clock, sustained, for loads and renders alike; busy stays low.
// A render returns out_pixel after the registered read of the two texture RAMs, then
// after the key select and output register.
// Loads write their RAM in the accepting cycle and produce no result.
// Reset clears only the pipeline valid bits; the texture RAMs are not cleared and must
// be loaded before they are rendered. The receiver cannot stall the result strobe.
//
module color_keyed_scrolling_overlay_unit #(
  // Side of the square layers; a power of two from 16 to 128.
  parameter int TILE_SIDE = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  ckso_pkg::row_t   in_row,
  input  ckso_pkg::col_t   in_col,
  input  ckso_pkg::pixel_t in_texel,
  input  ckso_pkg::shift_t in_shift,
  output logic             out_valid,
  output ckso_pkg::pixel_t out_pixel
);
  import ckso_pkg::*;

  localparam int SW    = $clog2(TILE_SIDE);
  localparam int AW    = 2 * SW;
  localparam int DEPTH = TILE_SIDE * TILE_SIDE;

  ctl_t          ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] ov_raddr;
  logic [AW-1:0] bg_raddr;
  pixel_t        ov_wdata;
  pixel_t        ov_rdata;
  pixel_t        bg_rdata;

  // No item ever has to wait: every transaction is a single RAM access per store.
  assign busy = 1'b0;

  // Decode: which store a load writes, keyed overlay data, render addresses
  // (overlay shifted with wrap-around, background unshifted).
  ckso_addr #(
    .TILE_SIDE (TILE_SIDE)
  ) u_addr (
    .start    (start),
    .busy     (busy),
    .cmd      (in_cmd),
    .row      (in_row),
    .col      (in_col),
    .texel    (in_texel),
    .shift    (in_shift),
    .ctl      (ctl),
    .waddr    (waddr),
    .ov_wdata (ov_wdata),
    .ov_raddr (ov_raddr),
    .bg_raddr (bg_raddr)
  );

  // Overlay layer. A write lands at the accepting edge, so a render taken in the
  // next cycle already reads the new texel; no forwarding path is needed.
  ckso_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ov_ram (
    .clk   (clk),
    .we    (ctl.ov_we),
    .waddr (waddr),
    .wdata (ov_wdata),
    .re    (ctl.rd_en),
    .raddr (ov_raddr),
    .rdata (ov_rdata)
  );

  // Background layer, stored as loaded.
  ckso_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_bg_ram (
    .clk   (clk),
    .we    (ctl.bg_we),
    .waddr (waddr),
    .wdata (in_texel),
    .re    (ctl.rd_en),
    .raddr (bg_raddr),
    .rdata (bg_rdata)
  );

  // Color-key select and output register.
  ckso_compose u_compose (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (ctl.rd_en),
    .ov_rdata  (ov_rdata),
    .bg_rdata  (bg_rdata),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  // Every strobe traces back to an accepted render.
  `CKSO_ASSERT_ALWAYS(a_strobe_from_render, clk, out_valid |-> $past(start && !busy && in_cmd == CMD_RENDER, 2), "result strobe without a render")

  // A load never yields a result.
  `CKSO_ASSERT(a_load_silent, clk, rst_n, (start && !busy && in_cmd == CMD_LOAD) |=> ##1 !out_valid, "load produced a result")

  // A load writes at most one of the two stores, and never alongside a render.
  `CKSO_ASSERT_ALWAYS(a_one_access, clk, $onehot0({ctl.ov_we, ctl.bg_we, ctl.rd_en}), "overlapping store accesses")

endmodule
